[rtl/core/qls_pkg.sv]
// ----------------------------------------------------------------------------
// qls_pkg: shared definitions of the query lexer
// Record and token codes, column and number widths, the word formats that
// travel between the lexer front, the fraction divider, the queue and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qls_pkg;

   // Query length limit; column counts saturate here.
   localparam int MAX_QUERY_LEN   = 4096;
   // Fraction digits that count toward a number's value.
   localparam int FRACTION_DIGITS = 9;

   localparam int COL_W    = 13;
   localparam int INT_W    = 16;
   localparam int QUOT_W   = 16;
   localparam int NUM_W    = INT_W + QUOT_W;
   localparam int FRAC_W   = 30;
   localparam int FCNT_W   = 4;
   localparam int RECS_MAX = 4;
   localparam int CNT_W    = $clog2(RECS_MAX + 1);
   localparam int IDX_W    = $clog2(RECS_MAX);
   localparam int QUEUE_DEPTH = 4;

   // Record types.
   localparam logic [1:0] REC_VALUE = 2'd0;
   localparam logic [1:0] REC_TOKEN = 2'd1;
   localparam logic [1:0] REC_END   = 2'd2;

   // Token kinds.
   localparam logic [2:0] KIND_IDENT  = 3'd0;
   localparam logic [2:0] KIND_STRING = 3'd1;
   localparam logic [2:0] KIND_NUMBER = 3'd2;
   localparam logic [2:0] KIND_LPAREN = 3'd3;
   localparam logic [2:0] KIND_RPAREN = 3'd4;
   localparam logic [2:0] KIND_COMMA  = 3'd5;
   localparam logic [2:0] KIND_PIPE   = 3'd6;
   localparam logic [2:0] KIND_ERROR  = 3'd7;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_IDENT = 3'd1,
      MODE_STR   = 3'd2,
      MODE_ESC   = 3'd3,
      MODE_NUM   = 3'd4
   } lex_mode_type;

   // One result word without its number value.
   typedef struct packed {
      logic [1:0]       rtype;
      logic [2:0]       kind;
      logic [7:0]       vchar;
      logic [COL_W-1:0] col_start;
      logic [COL_W-1:0] col_end;
   } lex_rec_type;

   // All result words caused by one input word, plus the integer part of a
   // number token among them.
   typedef struct packed {
      logic [CNT_W-1:0]                cnt;
      lex_rec_type [RECS_MAX-1:0]      recs;
      logic [INT_W-1:0]                int_part;
      logic                            neg;
   } lex_bundle_type;

   // Fraction digits of a number token, to be scaled by the divider.
   typedef struct packed {
      logic [FRAC_W-1:0] frac;
      logic [FCNT_W-1:0] fcnt;
   } lex_frac_type;

   // Queue entry: the result words with the finished number value.
   typedef struct packed {
      logic [IDX_W-1:0]           last;
      lex_rec_type [RECS_MAX-1:0] recs;
      logic [NUM_W-1:0]           num;
   } lex_entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // Powers of ten for the fraction scale.
   function automatic logic [FRAC_W-1:0] pow10(logic [FCNT_W-1:0] k);
      logic [FRAC_W-1:0] p;
      case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/core/qls_front.sv]
// ----------------------------------------------------------------------------
// qls_front: character classifier and lexer state
// Takes one query character per word, tracks the token being built and
// produces every result word that the character causes in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qls_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              char_in,
   input  logic                    final_char,
   output qls_pkg::lex_bundle_type bundle,
   output qls_pkg::lex_frac_type   frac_out
);
   import qls_pkg::*;

   typedef struct packed {
      logic [INT_W-1:0]  int_part;
      logic [FRAC_W-1:0] frac;
      logic [FCNT_W-1:0] fcnt;
      logic              neg;
      logic              dot;
      logic              stop;
      logic              digit;
   } num_state_type;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ESC_A  = 8'h61;
   localparam logic [7:0] CH_ESC_B  = 8'h62;
   localparam logic [7:0] CH_ESC_N  = 8'h6E;
   localparam logic [7:0] CH_ESC_R  = 8'h72;
   localparam logic [7:0] CH_ESC_T  = 8'h74;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_HT     = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_RET    = 8'h0D;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [7:0] esc_decode(logic [7:0] c);
      logic [7:0] d;
      case (c)
         CH_ESC_A: d = CH_BEL;
         CH_ESC_N: d = CH_LF;
         CH_ESC_R: d = CH_RET;
         CH_ESC_T: d = CH_HT;
         CH_ESC_B: d = CH_BS;
         default:  d = c;
      endcase
      return d;
   endfunction

   function automatic lex_rec_type mk_rec(logic [1:0] rtype, logic [2:0] kind,
                                          logic [7:0] ch, logic [COL_W-1:0] cs,
                                          logic [COL_W-1:0] ce);
      lex_rec_type r;
      r.rtype     = rtype;
      r.kind      = kind;
      r.vchar     = ch;
      r.col_start = cs;
      r.col_end   = ce;
      return r;
   endfunction

   function automatic lex_bundle_type push_rec(lex_bundle_type b, lex_rec_type r);
      lex_bundle_type o;
      o = b;
      if (b.cnt < CNT_W'(RECS_MAX)) begin
         o.recs[b.cnt[IDX_W-1:0]] = r;
         o.cnt = b.cnt + CNT_W'(1);
      end
      return o;
   endfunction

   // A number with no digit closes as an error token.
   function automatic lex_rec_type close_rec(num_state_type s, logic [COL_W-1:0] cs,
                                             logic [COL_W-1:0] ce);
      return mk_rec(REC_TOKEN, s.digit ? KIND_NUMBER : KIND_ERROR, 8'd0, cs, ce);
   endfunction

   // One digit or dot of a number run.
   function automatic num_state_type num_step(num_state_type s, logic [7:0] c);
      num_state_type     r;
      logic [INT_W+3:0]  iv;
      logic [FRAC_W+3:0] fv;
      r  = s;
      iv = ({4'd0, s.int_part} << 3) + ({4'd0, s.int_part} << 1)
           + {{INT_W{1'b0}}, c[3:0]};
      fv = ({4'd0, s.frac} << 3) + ({4'd0, s.frac} << 1) + {{FRAC_W{1'b0}}, c[3:0]};
      if (!s.stop) begin
         if (c == CH_DOT) begin
            if (s.dot) begin
               r.stop = 1'b1;
            end else begin
               r.dot = 1'b1;
            end
         end else begin
            r.digit = 1'b1;
            if (!s.dot) begin
               r.int_part = (|iv[INT_W+3:INT_W]) ? {INT_W{1'b1}} : iv[INT_W-1:0];
            end else if (s.fcnt < FCNT_W'(FRACTION_DIGITS)) begin
               r.frac = fv[FRAC_W-1:0];
               r.fcnt = s.fcnt + FCNT_W'(1);
            end
         end
      end
      return r;
   endfunction

   lex_mode_type     mode_ff, mode_in;
   logic             quote_ff, quote_in;
   logic [COL_W-1:0] col_ff, col_in, col_nxt;
   logic [COL_W-1:0] tok_ff, tok_in;
   num_state_type    num_ff, num_in;
   logic             do_idle;

   // Saturating column of the character after this one.
   assign col_nxt = (col_ff >= COL_W'(MAX_QUERY_LEN)) ? COL_W'(MAX_QUERY_LEN)
                                                      : col_ff + COL_W'(1);

   // Lexer step: mode handling, then a restart from idle, then query end.
   always_comb begin
      bundle   = '0;
      frac_out = '0;
      mode_in  = mode_ff;
      quote_in = quote_ff;
      col_in   = col_nxt;
      tok_in   = tok_ff;
      num_in   = num_ff;
      do_idle  = 1'b0;

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_word(char_in)) begin
               bundle = push_rec(bundle,
                                 mk_rec(REC_VALUE, KIND_IDENT, char_in, col_ff, col_nxt));
            end else begin
               bundle  = push_rec(bundle, mk_rec(REC_TOKEN, KIND_IDENT, 8'd0, tok_ff, col_ff));
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_NUM: begin
            if (is_digit(char_in) || (char_in == CH_DOT)) begin
               num_in = num_step(num_ff, char_in);
            end else begin
               bundle = push_rec(bundle, close_rec(num_ff, tok_ff, col_ff));
               if (num_ff.digit) begin
                  bundle.int_part = num_ff.int_part;
                  bundle.neg      = num_ff.neg;
                  frac_out.frac   = num_ff.frac;
                  frac_out.fcnt   = num_ff.fcnt;
               end
               num_in  = '0;
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_STR: begin
            if (char_in == (quote_ff ? CH_SQUOTE : CH_DQUOTE)) begin
               bundle  = push_rec(bundle,
                                  mk_rec(REC_TOKEN, KIND_STRING, 8'd0, tok_ff, col_nxt));
               mode_in = MODE_IDLE;
            end else if (char_in == CH_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               bundle = push_rec(bundle,
                                 mk_rec(REC_VALUE, KIND_STRING, char_in, col_ff, col_nxt));
            end
         end
         MODE_ESC: begin
            bundle  = push_rec(bundle, mk_rec(REC_VALUE, KIND_STRING, esc_decode(char_in),
                                              col_ff, col_nxt));
            mode_in = MODE_STR;
         end
         default: begin
            mode_in = MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      // Character seen between tokens.
      if (do_idle && !is_space(char_in)) begin
         if (char_in == CH_LPAREN) begin
            bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_LPAREN, 8'd0, col_ff, col_nxt));
         end else if (char_in == CH_RPAREN) begin
            bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_RPAREN, 8'd0, col_ff, col_nxt));
         end else if (char_in == CH_COMMA) begin
            bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_COMMA, 8'd0, col_ff, col_nxt));
         end else if (char_in == CH_PIPE) begin
            bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_PIPE, 8'd0, col_ff, col_nxt));
         end else if ((char_in == CH_DQUOTE) || (char_in == CH_SQUOTE)) begin
            mode_in  = MODE_STR;
            quote_in = (char_in == CH_SQUOTE);
            tok_in   = col_ff;
         end else if (is_digit(char_in) || (char_in == CH_MINUS)) begin
            mode_in = MODE_NUM;
            tok_in  = col_ff;
            num_in  = '0;
            if (char_in == CH_MINUS) begin
               num_in.neg = 1'b1;
            end else begin
               num_in = num_step(num_in, char_in);
            end
         end else if (is_alpha(char_in) || (char_in == CH_UNDER)) begin
            mode_in = MODE_IDENT;
            tok_in  = col_ff;
            bundle  = push_rec(bundle,
                               mk_rec(REC_VALUE, KIND_IDENT, char_in, col_ff, col_nxt));
         end else begin
            // Unknown byte: keep it as a value, then a one-column error token.
            bundle = push_rec(bundle, mk_rec(REC_VALUE, KIND_ERROR, char_in, col_ff, col_nxt));
            bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_ERROR, 8'd0, col_ff, col_nxt));
         end
      end

      // Query end closes any open token, sends the end word and starts over.
      if (final_char) begin
         case (mode_in) inside
            MODE_IDENT: begin
               bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_IDENT, 8'd0, tok_in, col_nxt));
            end
            MODE_NUM: begin
               bundle = push_rec(bundle, close_rec(num_in, tok_in, col_nxt));
               if (num_in.digit) begin
                  bundle.int_part = num_in.int_part;
                  bundle.neg      = num_in.neg;
                  frac_out.frac   = num_in.frac;
                  frac_out.fcnt   = num_in.fcnt;
               end
            end
            MODE_STR, MODE_ESC: begin
               bundle = push_rec(bundle, mk_rec(REC_TOKEN, KIND_ERROR, 8'd0, tok_in, col_nxt));
            end
            default: begin
            end
         endcase
         bundle   = push_rec(bundle, mk_rec(REC_END, KIND_IDENT, 8'd0, col_nxt, col_nxt));
         mode_in  = MODE_IDLE;
         quote_in = 1'b0;
         col_in   = '0;
         tok_in   = '0;
         num_in   = '0;
      end
   end

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         quote_ff <= 1'b0;
         col_ff   <= '0;
         tok_ff   <= '0;
         num_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         col_ff   <= col_in;
         tok_ff   <= tok_in;
         num_ff   <= num_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/qls_frac_div.sv]
// ----------------------------------------------------------------------------
// qls_frac_div: number value pipeline
// Carries each group of result words through a restoring divider that turns
// the decimal fraction into sixteen binary places, one bit per stage, then
// joins the integer part and saturates the signed Q16.16 value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qls_frac_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  qls_pkg::lex_bundle_type   in_bundle,
   input  qls_pkg::lex_frac_type     in_frac,
   input  qls_pkg::queue_status_type q_status,
   output logic                      advance,
   output logic                      out_valid,
   output qls_pkg::lex_entry_type    out_entry
);
   import qls_pkg::*;

   typedef struct packed {
      lex_bundle_type    bundle;
      logic [FRAC_W-1:0] rem;
      logic [FRAC_W-1:0] divisor;
      logic [QUOT_W-1:0] quot;
   } div_stage_type;

   localparam int STAGES = QUOT_W + 1;
   localparam logic [NUM_W-1:0] NEG_LIMIT = {1'b1, {(NUM_W-1){1'b0}}};
   localparam logic [NUM_W-1:0] POS_LIMIT = {1'b0, {(NUM_W-1){1'b1}}};

   // One quotient bit: double the remainder and take the divisor out if it fits.
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type   r;
      logic [FRAC_W:0] t;
      r = s;
      t = {s.rem, 1'b0};
      if (t >= {1'b0, s.divisor}) begin
         r.rem  = FRAC_W'(t - {1'b0, s.divisor});
         r.quot = {s.quot[QUOT_W-2:0], 1'b1};
      end else begin
         r.rem  = t[FRAC_W-1:0];
         r.quot = {s.quot[QUOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   div_stage_type     stage_ff [STAGES];
   logic [STAGES-1:0] valid_ff;
   div_stage_type     seed;
   div_stage_type     tail;
   logic [NUM_W-1:0]  mag;
   logic [NUM_W-1:0]  sat;
   logic [NUM_W-1:0]  value;

   // The whole pipeline holds while its last word waits on a full queue.
   assign advance   = !(valid_ff[STAGES-1] && q_status.full);
   assign out_valid = valid_ff[STAGES-1] && !q_status.full;

   // Remainder starts as the fraction digits, divisor as its power of ten.
   always_comb begin
      seed.bundle  = in_bundle;
      seed.rem     = in_frac.frac;
      seed.divisor = pow10(in_frac.fcnt);
      seed.quot    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff[0] <= seed;
         for (int k = 1; k < STAGES; k++) begin
            stage_ff[k] <= div_step(stage_ff[k-1]);
         end
      end
   end

   // Magnitude, saturation and sign of the finished value.
   always_comb begin
      tail = stage_ff[STAGES-1];
      mag  = {tail.bundle.int_part, tail.quot};
      if (tail.bundle.neg) begin
         sat   = (mag > NEG_LIMIT) ? NEG_LIMIT : mag;
         value = ~sat + NUM_W'(1);
      end else begin
         sat   = (mag > POS_LIMIT) ? POS_LIMIT : mag;
         value = sat;
      end
      out_entry.last = IDX_W'(tail.bundle.cnt - CNT_W'(1));
      out_entry.recs = tail.bundle.recs;
      out_entry.num  = value;
   end

endmodule

`default_nettype wire

[rtl/core/qls_fifo.sv]
// ----------------------------------------------------------------------------
// qls_fifo: queue between the value pipeline and the result side
// Four entries of finished result groups, so that the lexer keeps taking
// characters while the result side is stalled, until the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qls_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  qls_pkg::lex_entry_type    push_entry,
   input  logic                      pop,
   output qls_pkg::lex_entry_type    head,
   output qls_pkg::queue_status_type status
);
   import qls_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   lex_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = (fill_ff != '0);
   assign status.full      = (fill_ff == FILL_W'(QUEUE_DEPTH));

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/qls_back.sv]
// ----------------------------------------------------------------------------
// qls_back: result serializer
// Holds one queue entry and hands out its result words one per cycle while
// rsp_stall is low, marking the last word of the group caused by one input character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qls_back (
   input  logic                          clock,
   input  logic                          reset,
   input  qls_pkg::lex_entry_type        head,
   input  qls_pkg::queue_status_type     q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_record_type,
   output logic [2:0]                    rsp_token_kind,
   output logic [7:0]                    rsp_value_char,
   output logic [qls_pkg::COL_W-1:0]     rsp_col_start,
   output logic [qls_pkg::COL_W-1:0]     rsp_col_end,
   output logic signed [qls_pkg::NUM_W-1:0] rsp_number_value,
   output logic                          rsp_run_end
);
   import qls_pkg::*;

   lex_entry_type    cur_ff;
   logic             cur_valid_ff;
   logic [IDX_W-1:0] idx_ff;
   lex_rec_type      rec;
   logic             take;
   logic             is_last;

   assign take    = cur_valid_ff && !rsp_stall;
   assign is_last = (idx_ff == cur_ff.last);
   // Load the next entry when nothing is held or the last word just left.
   assign pop     = q_status.not_empty && (!cur_valid_ff || (take && is_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (take) begin
         if (is_last) begin
            cur_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   // Present the current word; only a number token carries the value.
   assign rec              = cur_ff.recs[idx_ff];
   assign rsp_valid        = cur_valid_ff;
   assign rsp_record_type  = rec.rtype;
   assign rsp_token_kind   = rec.kind;
   assign rsp_value_char   = rec.vchar;
   assign rsp_col_start    = rec.col_start;
   assign rsp_col_end      = rec.col_end;
   assign rsp_run_end      = is_last;
   assign rsp_number_value = ((rec.rtype == REC_TOKEN) && (rec.kind == KIND_NUMBER))
                             ? signed'(cur_ff.num) : '0;

endmodule

`default_nettype wire

[rtl/core/query_lexer_stream.sv]
// ----------------------------------------------------------------------------
// query_lexer_stream: streaming query lexer
// Path: an accepted character word passes the 16-stage fraction divider, the
//    queue and the result register before its first result word appears.
// Throughput: one character word per cycle while the value pipeline moves.
// Reset (synchronous): column 0, between tokens; pipeline and queue empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module query_lexer_stream (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_char_in,
   input  logic                          req_final_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_record_type,
   output logic [2:0]                    rsp_token_kind,
   output logic [7:0]                    rsp_value_char,
   output logic [qls_pkg::COL_W-1:0]     rsp_col_start,
   output logic [qls_pkg::COL_W-1:0]     rsp_col_end,
   output logic signed [qls_pkg::NUM_W-1:0] rsp_number_value,
   output logic                          rsp_run_end
);
   import qls_pkg::*;

   logic             accept;
   logic             advance;
   logic             div_in_valid;
   logic             push;
   logic             pop;
   lex_bundle_type   bundle;
   lex_frac_type     frac;
   lex_entry_type    push_entry;
   lex_entry_type    head;
   queue_status_type q_status;

   // A character word is taken whenever the value pipeline moves.
   assign req_stall    = !advance;
   assign accept       = req_valid && !req_stall;
   assign div_in_valid = accept && (bundle.cnt != '0);

   qls_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_in    (req_char_in),
      .final_char (req_final_char),
      .bundle     (bundle),
      .frac_out   (frac)
   );

   qls_frac_div u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_in_valid),
      .in_bundle (bundle),
      .in_frac   (frac),
      .q_status  (q_status),
      .advance   (advance),
      .out_valid (push),
      .out_entry (push_entry)
   );

   qls_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   qls_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_type  (rsp_record_type),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_value_char   (rsp_value_char),
      .rsp_col_start    (rsp_col_start),
      .rsp_col_end      (rsp_col_end),
      .rsp_number_value (rsp_number_value),
      .rsp_run_end      (rsp_run_end)
   );

endmodule

`default_nettype wire
